FILE: sv/tfs_pkg.sv
package tfs_pkg;

  localparam int unsigned ValueCount = 6;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned FrameBytes = 18;
  localparam int unsigned IdxWidth   = $clog2(FrameBytes);

  localparam logic [7:0] HeadByte0  = 8'hA5;
  localparam logic [7:0] HeadByte1  = 8'h5A;
  localparam logic [7:0] LenByte    = 8'(14 + 2);
  localparam logic [7:0] TypeByte   = 8'hA1;
  localparam logic [7:0] CheckSeed  = 8'(8'hAF + 2);
  localparam logic [7:0] TailByte   = 8'hAA;

  localparam logic [ValueWidth-1:0] SignBit = ValueWidth'(32768);

  // byte positions within a frame
  localparam logic [IdxWidth-1:0] PosHead0    = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] PosHead1    = IdxWidth'(1);
  localparam logic [IdxWidth-1:0] PosLen      = IdxWidth'(2);
  localparam logic [IdxWidth-1:0] PosType     = IdxWidth'(3);
  localparam logic [IdxWidth-1:0] PosData     = IdxWidth'(4);
  localparam logic [IdxWidth-1:0] PosChecksum = IdxWidth'(4 + 2 * ValueCount);
  localparam logic [IdxWidth-1:0] PosTail     = IdxWidth'(FrameBytes - 1);

  typedef logic [ValueCount-1:0][ValueWidth-1:0] value_vec_t;

  typedef struct packed {
    value_vec_t word;
    logic [7:0] checksum;
  } frame_t;

  // two's complement to sign-magnitude, most negative value wraps to zero
  function automatic logic [ValueWidth-1:0] encode_value(input logic [ValueWidth-1:0] raw);
    logic [ValueWidth-1:0] enc;
    if (raw[ValueWidth-1]) begin
      enc = SignBit - raw;
    end else begin
      enc = raw;
    end
    return enc;
  endfunction

endpackage

FILE: sv/tfs_if.sv
interface tfs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tfs_pkg::ValueWidth-1:0] yaw_angle;
  logic signed [tfs_pkg::ValueWidth-1:0] pitch_angle;
  logic signed [tfs_pkg::ValueWidth-1:0] roll_angle;
  logic signed [tfs_pkg::ValueWidth-1:0] altitude_value;
  logic signed [tfs_pkg::ValueWidth-1:0] temperature_value;
  logic signed [tfs_pkg::ValueWidth-1:0] pressure_value;

  modport source (
    output valid, yaw_angle, pitch_angle, roll_angle, altitude_value,
           temperature_value, pressure_value,
    input  ready
  );
  modport sink (
    input  valid, yaw_angle, pitch_angle, roll_angle, altitude_value,
           temperature_value, pressure_value,
    output ready
  );
endinterface

interface tfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (
    output valid, frame_byte, frame_last,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_last,
    output ready
  );
endinterface

FILE: sv/telemetry_frame_serializer.sv
// the first frame byte is offered once the item has passed the input register and been loaded into the byte sender
// throughput: one frame byte per cycle while the sink keeps ready high, set by the byte sender
// an item is held in the input register while the previous frame is still going out,
// so frames follow each other with no gap while the sink keeps ready high
// reset: asynchronous, active low; clears valid flags and byte position, no frame pending
module telemetry_frame_serializer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfs_in_if.sink    in_i,
  tfs_out_if.source out_o
);

  tfs_pkg::value_vec_t raw_q;
  logic                in_valid_q;
  logic                snd_ready;
  tfs_pkg::frame_t     frame;

  assign in_i.ready = !in_valid_q || snd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      raw_q <= {in_i.pressure_value, in_i.temperature_value, in_i.altitude_value,
                in_i.roll_angle, in_i.pitch_angle, in_i.yaw_angle};
    end
  end

  tfs_encoder u_encoder (
    .raw_i   (raw_q),
    .frame_o (frame)
  );

  tfs_byte_sender u_sender (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (snd_ready),
    .frame_i (frame),
    .out_o   (out_o)
  );

endmodule

FILE: sv/tfs_encoder.sv
module tfs_encoder (
  input  tfs_pkg::value_vec_t raw_i,
  output tfs_pkg::frame_t     frame_o
);

  logic [tfs_pkg::ValueCount-1:0][7:0] pair_sum;

  // checksum over the seed and the twelve data bytes, low eight bits kept
  always_comb begin
    frame_o.checksum = tfs_pkg::CheckSeed;
    for (int i = 0; i < tfs_pkg::ValueCount; i++) begin
      frame_o.word[i]  = tfs_pkg::encode_value(raw_i[i]);
      pair_sum[i]      = frame_o.word[i][15:8] + frame_o.word[i][7:0];
      frame_o.checksum = frame_o.checksum + pair_sum[i];
    end
  end

endmodule

FILE: sv/tfs_byte_sender.sv
module tfs_byte_sender (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tfs_pkg::frame_t   frame_i,
  tfs_out_if.source         out_o
);

  tfs_pkg::frame_t                frame_q;
  logic                           valid_q, valid_d;
  logic [tfs_pkg::IdxWidth-1:0]   idx_q, idx_d;
  logic                           take;
  logic                           at_tail;
  logic                           load;
  logic [3:0]                     data_idx;
  logic [2:0]                     word_sel;

  assign at_tail = (idx_q == tfs_pkg::PosTail);
  assign take    = valid_q && out_o.ready;
  assign ready_o = !valid_q || (take && at_tail);
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = tfs_pkg::PosHead0;
    end else if (take) begin
      if (at_tail) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
  end

  // byte select
  assign data_idx = 4'(idx_q - tfs_pkg::PosData);
  assign word_sel = data_idx[3:1];

  always_comb begin
    priority if (idx_q == tfs_pkg::PosHead0) begin
      out_o.frame_byte = tfs_pkg::HeadByte0;
    end else if (idx_q == tfs_pkg::PosHead1) begin
      out_o.frame_byte = tfs_pkg::HeadByte1;
    end else if (idx_q == tfs_pkg::PosLen) begin
      out_o.frame_byte = tfs_pkg::LenByte;
    end else if (idx_q == tfs_pkg::PosType) begin
      out_o.frame_byte = tfs_pkg::TypeByte;
    end else if (idx_q < tfs_pkg::PosChecksum) begin
      out_o.frame_byte = data_idx[0] ? frame_q.word[word_sel][7:0]
                                     : frame_q.word[word_sel][15:8];
    end else if (idx_q == tfs_pkg::PosChecksum) begin
      out_o.frame_byte = frame_q.checksum;
    end else begin
      out_o.frame_byte = tfs_pkg::TailByte;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.frame_last = at_tail;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= tfs_pkg::PosTail))
    else $error("byte index past end of frame");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (valid_q && idx_q == tfs_pkg::PosHead0))
    else $error("new frame does not start at header");

  a_tail_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && at_tail && !valid_i) |=> !valid_q)
    else $error("frame continues after tail byte");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |=> (valid_q && $stable(idx_q)))
    else $error("byte position moved while stalled");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !at_tail) |=> (idx_q == $past(idx_q) + 1'b1))
    else $error("byte position skipped");

endmodule
